// ----- hdl/smv_pkg.sv -----
// Shared widths, constants and the queued operation type of the sparse matrix-vector engine
package smv_pkg;

    localparam int MAX_DIM_DEFAULT = 1024;

    localparam int FUNC_W      = 2;
    localparam int IDX_W       = 10;
    localparam int DATA_W      = 32;
    localparam int DIM_W       = 11;
    localparam int ACC_W       = 48;
    localparam int FRAC_W      = 24;
    localparam int PROD_W      = 2 * DATA_W - FRAC_W;
    localparam int CFG_IDX_W   = 1;
    localparam int QUEUE_DEPTH = 2;

    // request function codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD_X = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ENTRY  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ_Y = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_SPARE  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_MODE = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_ENTRY,
        OP_ENTRY_SYM,
        OP_READ
    } t_op_kind;

    typedef struct packed {
        t_op_kind                  kind;
        logic [IDX_W-1:0]          row_index;
        logic [IDX_W-1:0]          col_index;
        logic signed [DATA_W-1:0]  data_value;
    } t_op;

endpackage

// ----- hdl/smv_req_if.sv -----
// Request channel: valid/ready handshake with one input item as payload
interface smv_req_if;
    logic                               valid;
    logic                               ready;
    logic [smv_pkg::FUNC_W-1:0]         func;
    logic [smv_pkg::IDX_W-1:0]          row_index;
    logic [smv_pkg::IDX_W-1:0]          col_index;
    logic signed [smv_pkg::DATA_W-1:0]  data_value;

    modport source (output valid, func, row_index, col_index, data_value, input ready);
    modport sink   (input valid, func, row_index, col_index, data_value, output ready);
endinterface

// ----- hdl/smv_rsp_if.sv -----
// Result channel: valid/ready handshake carrying one y element
interface smv_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [smv_pkg::IDX_W-1:0]          result_index;
    logic signed [smv_pkg::ACC_W-1:0]   result_value;

    modport source (output valid, result_index, result_value, input ready);
    modport sink   (input valid, result_index, result_value, output ready);
endinterface

// ----- hdl/smv_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module smv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/smv_front.sv -----
// Front end: accepts requests, range-checks them and turns them into queued operations
module smv_front #(
    parameter int MAX_DIM = smv_pkg::MAX_DIM_DEFAULT
) (
    smv_req_if.sink                    i_req,
    input  logic [smv_pkg::DIM_W-1:0]  i_dimension,
    input  logic                       i_lower_mode,
    input  logic                       i_queue_full,
    input  logic                       i_init_done,
    output logic                       o_push,
    output smv_pkg::t_op               o_op
);

    logic row_ok;
    logic col_ok;
    logic keep;

    assign row_ok = ({1'b0, i_req.row_index} < i_dimension)
                 && (32'(i_req.row_index) < 32'(MAX_DIM));
    assign col_ok = ({1'b0, i_req.col_index} < i_dimension)
                 && (32'(i_req.col_index) < 32'(MAX_DIM));

    always_comb begin
        o_op.row_index  = i_req.row_index;
        o_op.col_index  = i_req.col_index;
        o_op.data_value = i_req.data_value;
        case (i_req.func)
            smv_pkg::FUNC_LOAD_X: begin
                keep      = row_ok;
                o_op.kind = smv_pkg::OP_LOAD;
            end
            smv_pkg::FUNC_ENTRY: begin
                keep      = row_ok && col_ok;
                // mirror off-diagonal entries when only one triangle is stored
                o_op.kind = (i_lower_mode && (i_req.row_index != i_req.col_index))
                          ? smv_pkg::OP_ENTRY_SYM : smv_pkg::OP_ENTRY;
            end
            smv_pkg::FUNC_READ_Y: begin
                keep      = row_ok;
                o_op.kind = smv_pkg::OP_READ;
            end
            default: begin
                keep      = 1'b0;
                o_op.kind = smv_pkg::OP_LOAD;
            end
        endcase
    end

    assign i_req.ready = !i_queue_full && i_init_done;
    // drop out-of-range and unused requests here; they never reach the back end
    assign o_push      = i_req.valid && i_req.ready && keep;

endmodule

// ----- hdl/smv_queue.sv -----
// Short operation queue between the front end and the back end
module smv_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  smv_pkg::t_op  i_op,
    input  logic          i_pop,
    output smv_pkg::t_op  o_op,
    output logic          o_full,
    output logic          o_empty
);

    localparam int DEPTH = smv_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    smv_pkg::t_op     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wptr;
    logic [PTR_W-1:0] n_rptr;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_op    = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (do_push) begin
            r_mem[r_wptr] <= i_op;
        end
    end

endmodule

// ----- hdl/smv_back.sv -----
// Back end: x and y memories, multiply-accumulate sequencer and the result register
module smv_back #(
    parameter int MAX_DIM = smv_pkg::MAX_DIM_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  smv_pkg::t_op  i_op,
    output logic          o_pop,
    output logic          o_init_done,
    smv_rsp_if.source     o_rsp
);

    localparam int AW     = $clog2(MAX_DIM);
    localparam int DATA_W = smv_pkg::DATA_W;
    localparam int ACC_W  = smv_pkg::ACC_W;
    localparam int PROD_W = smv_pkg::PROD_W;
    localparam int IDX_W  = smv_pkg::IDX_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_ACC,
        S_OUT
    } t_state;

    t_state              r_state, n_state;
    smv_pkg::t_op        r_op, n_op;
    logic                r_second, n_second;
    logic [AW-1:0]       r_clr_cnt, n_clr_cnt;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic                r_out_valid, n_out_valid;
    logic [IDX_W-1:0]    r_out_idx, n_out_idx;
    logic [ACC_W-1:0]    r_out_val, n_out_val;

    logic                x_we, x_re;
    logic [AW-1:0]       x_waddr, x_raddr;
    logic [DATA_W-1:0]   x_wdata, x_rdata;
    logic                y_we, y_re;
    logic [AW-1:0]       y_waddr, y_raddr;
    logic [ACC_W-1:0]    y_wdata, y_rdata;

    logic signed [2*DATA_W-1:0] w_prod;
    logic [ACC_W:0]             w_sum;
    logic [ACC_W-1:0]           w_sat;

    smv_ram #(.WIDTH(DATA_W), .DEPTH(MAX_DIM)) u_x_ram (
        .i_clk   (i_clk),
        .i_we    (x_we),
        .i_waddr (x_waddr),
        .i_wdata (x_wdata),
        .i_re    (x_re),
        .i_raddr (x_raddr),
        .o_rdata (x_rdata)
    );

    smv_ram #(.WIDTH(ACC_W), .DEPTH(MAX_DIM)) u_y_ram (
        .i_clk   (i_clk),
        .i_we    (y_we),
        .i_waddr (y_waddr),
        .i_wdata (y_wdata),
        .i_re    (y_re),
        .i_raddr (y_raddr),
        .o_rdata (y_rdata)
    );

    // Q8.24 x Q8.24 is exact in Q16.48; keep the Q16.24 part (floor)
    assign w_prod = $signed(r_op.data_value) * $signed(x_rdata);

    // y read data holds until the next read, so it is still valid in S_ACC
    assign w_sum = {y_rdata[ACC_W-1], y_rdata}
                 + {{(ACC_W + 1 - PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_comb begin
        if (w_sum[ACC_W] != w_sum[ACC_W-1]) begin
            w_sat = w_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            w_sat = w_sum[ACC_W-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_second    = r_second;
        n_clr_cnt   = r_clr_cnt;
        n_prod      = r_prod;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_idx   = r_out_idx;
        n_out_val   = r_out_val;
        o_pop       = 1'b0;
        x_we        = 1'b0;
        x_waddr     = AW'(i_op.row_index);
        x_wdata     = i_op.data_value;
        x_re        = 1'b0;
        x_raddr     = AW'(i_op.col_index);
        y_we        = 1'b0;
        y_waddr     = AW'(r_op.row_index);
        y_wdata     = '0;
        y_re        = 1'b0;
        y_raddr     = AW'(i_op.row_index);

        case (r_state)
            S_CLEAR: begin
                y_we      = 1'b1;
                y_waddr   = r_clr_cnt;
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (r_clr_cnt == AW'(MAX_DIM - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop    = 1'b1;
                    n_op     = i_op;
                    n_second = 1'b0;
                    case (i_op.kind)
                        smv_pkg::OP_LOAD: begin
                            x_we = 1'b1;
                        end
                        smv_pkg::OP_ENTRY, smv_pkg::OP_ENTRY_SYM: begin
                            x_re    = 1'b1;
                            y_re    = 1'b1;
                            n_state = S_MUL;
                        end
                        smv_pkg::OP_READ: begin
                            y_re    = 1'b1;
                            n_state = S_OUT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_MUL: begin
                n_prod  = w_prod[2*DATA_W-1:smv_pkg::FRAC_W];
                n_state = S_ACC;
            end
            S_ACC: begin
                y_we    = 1'b1;
                y_waddr = r_second ? AW'(r_op.col_index) : AW'(r_op.row_index);
                y_wdata = w_sat;
                if (r_op.kind == smv_pkg::OP_ENTRY_SYM && !r_second) begin
                    // mirrored half: entry * x[row] into y[col]
                    x_re     = 1'b1;
                    x_raddr  = AW'(r_op.row_index);
                    y_re     = 1'b1;
                    y_raddr  = AW'(r_op.col_index);
                    n_second = 1'b1;
                    n_state  = S_MUL;
                end else begin
                    n_second = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            S_OUT: begin
                // hold until the result register is free, then clear the element
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = r_op.row_index;
                    n_out_val   = y_rdata;
                    y_we        = 1'b1;
                    y_waddr     = AW'(r_op.row_index);
                    y_wdata     = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_second    <= 1'b0;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_second    <= n_second;
            r_clr_cnt   <= n_clr_cnt;
            r_out_valid <= n_out_valid;
        end
        r_op      <= n_op;
        r_prod    <= n_prod;
        r_out_idx <= n_out_idx;
        r_out_val <= n_out_val;
    end

    assign o_init_done        = (r_state != S_CLEAR);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_index = r_out_idx;
    assign o_rsp.result_value = r_out_val;

endmodule

// ----- hdl/sparse_matvec_csr_symmetric.sv -----
// Sparse matrix-vector product engine, y = A*x, top level.
// Requests enter on i_req (valid/ready). func 0 loads x[row_index], func 1 adds
// data_value*x[col_index] into y[row_index] (and, in lower mode off the diagonal,
// data_value*x[row_index] into y[col_index]), func 2 returns y[row_index] on o_rsp
// and clears it. Values are signed Q8.24 in, Q24.24 out, saturated at 48 bits.
// Requests with an index at or above the dimension register are taken and dropped.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data while idle.
// After reset the y memory is cleared one word per cycle, and i_req.ready stays
// low until the last word is cleared. Configuration writes are taken as usual.
// A request passes a two-entry queue, then the back end handles it: a load
// writes x in S_IDLE; an entry reads x and y, multiplies in S_MUL and
// accumulates into y in S_ACC, repeating S_MUL and S_ACC for the mirrored half;
// a read moves y to the output register in S_OUT. These steps come from the
// single read port on each memory and the registered multiplier between read and
// accumulate. The result sits in an output register; while o_rsp is stalled,
// later loads and entries still proceed, and a further read waits in the back
// end until the register frees, the queue then filling and ready dropping.
module sparse_matvec_csr_symmetric #(
    parameter int MAX_DIM = smv_pkg::MAX_DIM_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [smv_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [smv_pkg::DIM_W-1:0]      i_cfg_data,
    smv_req_if.sink                        i_req,
    smv_rsp_if.source                      o_rsp
);

    logic [smv_pkg::DIM_W-1:0] r_dimension;
    logic                      r_lower_mode;

    logic          w_push;
    logic          w_pop;
    logic          w_q_full;
    logic          w_q_empty;
    logic          w_init_done;
    smv_pkg::t_op  w_push_op;
    smv_pkg::t_op  w_head_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dimension  <= smv_pkg::DIM_W'(1024);
            r_lower_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                smv_pkg::CFG_DIMENSION:  r_dimension  <= i_cfg_data;
                smv_pkg::CFG_LOWER_MODE: r_lower_mode <= i_cfg_data[0];
                default: begin
                    r_dimension <= r_dimension;
                end
            endcase
        end
    end

    smv_front #(.MAX_DIM(MAX_DIM)) u_front (
        .i_req        (i_req),
        .i_dimension  (r_dimension),
        .i_lower_mode (r_lower_mode),
        .i_queue_full (w_q_full),
        .i_init_done  (w_init_done),
        .o_push       (w_push),
        .o_op         (w_push_op)
    );

    smv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_push_op),
        .i_pop   (w_pop),
        .o_op    (w_head_op),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    smv_back #(.MAX_DIM(MAX_DIM)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_q_empty),
        .i_op        (w_head_op),
        .o_pop       (w_pop),
        .o_init_done (w_init_done),
        .o_rsp       (o_rsp)
    );

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("request pushed into a full queue");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_empty)
        else $error("operation popped from an empty queue");

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_init_done |-> !o_rsp.valid)
        else $error("result presented during the y clearing pass");

    a_no_push_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_init_done |=> w_q_empty || w_init_done)
        else $error("operation queued before the y clearing pass finished");

endmodule

// ----- tb/sv/sparse_matvec_csr_symmetric_tb.sv -----
// Self-checking testbench for the sparse matrix-vector engine: directed table, then random phases
module sparse_matvec_csr_symmetric_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FUNC_W        = smv_pkg::FUNC_W;
    localparam int IDX_W         = smv_pkg::IDX_W;
    localparam int DATA_W        = smv_pkg::DATA_W;
    localparam int DIM_W         = smv_pkg::DIM_W;
    localparam int ACC_W         = smv_pkg::ACC_W;
    localparam int FRAC_W        = smv_pkg::FRAC_W;
    localparam int CFG_IDX_W     = smv_pkg::CFG_IDX_W;
    localparam int MAX_DIM       = smv_pkg::MAX_DIM_DEFAULT;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_REQS    = 36;
    localparam int CFG_SETTLE    = 16;
    localparam int DRAIN_CYCLES  = 32;
    localparam int STALL_LIMIT   = 4000;
    localparam int MAX_REPORTS   = 10;
    localparam longint Y_HI      = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint Y_LO      = -Y_HI - 1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD  = smv_pkg::FUNC_LOAD_X,
        FUNC_ENTRY = smv_pkg::FUNC_ENTRY,
        FUNC_READ  = smv_pkg::FUNC_READ_Y,
        FUNC_SPARE = smv_pkg::FUNC_SPARE
    } t_func;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIMENSION  = smv_pkg::CFG_DIMENSION,
        REG_LOWER_MODE = smv_pkg::CFG_LOWER_MODE
    } t_cfg_reg;
    typedef enum bit {STEP_REQ, STEP_CFG} t_step_kind;

    typedef struct {
        t_step_kind        kind;
        t_cfg_reg          sel;
        t_func             func;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] data;
        bit                typed;
        logic [ACC_W-1:0]  val;
    } t_plan_row;

    typedef struct {
        logic [IDX_W-1:0] index;
        logic [ACC_W-1:0] value;
    } t_y_read;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [DIM_W-1:0]      i_cfg_data;

    smv_req_if req_ch();
    smv_rsp_if rsp_ch();

    sparse_matvec_csr_symmetric #(.MAX_DIM(MAX_DIM)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    // Predicted engine state
    logic signed [DATA_W-1:0] x_model [MAX_DIM];
    logic signed [ACC_W-1:0]  y_model [MAX_DIM];
    bit                       x_loaded [MAX_DIM];
    logic [DIM_W-1:0]         dim_model;
    logic                     lower_model;
    t_y_read                  y_reads_due [$];

    int mismatches;
    int n_loads;
    int n_entries;
    int n_reads;
    int n_spare;
    int n_results;
    int n_settings;
    int burst_left = 1;
    int idle_cycles;

    t_plan_row directed_plan [$] = '{
        '{STEP_REQ, REG_DIMENSION,  FUNC_READ,  10'd0,    10'd0,    32'h0000_0000, 1'b1, 48'h0},
        '{STEP_REQ, REG_DIMENSION,  FUNC_READ,  10'd1023, 10'd0,    32'h0000_0000, 1'b1, 48'h0},
        '{STEP_REQ, REG_DIMENSION,  FUNC_LOAD,  10'd0,    10'd0,    32'h7FFF_FFFF, 1'b0, 48'h0},
        '{STEP_REQ, REG_DIMENSION,  FUNC_LOAD,  10'd1023, 10'd0,    32'h8000_0000, 1'b0, 48'h0},
        '{STEP_REQ, REG_DIMENSION,  FUNC_LOAD,  10'd1,    10'd0,    32'h0100_0000, 1'b0, 48'h0},
        '{STEP_REQ, REG_DIMENSION,  FUNC_ENTRY, 10'd1,    10'd1,    32'h0200_0000, 1'b0, 48'h0},
        '{STEP_REQ, REG_DIMENSION,  FUNC_READ,  10'd1,    10'd0,    32'h0,
          1'b1, 48'h0000_0200_0000},
        '{STEP_REQ, REG_DIMENSION,  FUNC_ENTRY, 10'd0,    10'd0,    32'h7FFF_FFFF, 1'b0, 48'h0},
        '{STEP_REQ, REG_DIMENSION,  FUNC_ENTRY, 10'd1023, 10'd1023, 32'h8000_0000, 1'b0, 48'h0},
        '{STEP_REQ, REG_DIMENSION,  FUNC_READ,  10'd1023, 10'd0,    32'h0,
          1'b1, 48'h0040_0000_0000},
        '{STEP_REQ, REG_DIMENSION,  FUNC_ENTRY, 10'd0,    10'd1023, 32'h7FFF_FFFF, 1'b0, 48'h0},
        '{STEP_REQ, REG_DIMENSION,  FUNC_READ,  10'd0,    10'd0,    32'h0000_0000, 1'b0, 48'h0},
        '{STEP_REQ, REG_DIMENSION,  FUNC_SPARE, 10'd5,    10'd5,    32'hFFFF_FFFF, 1'b0, 48'h0},
        '{STEP_REQ, REG_DIMENSION,  FUNC_READ,  10'd0,    10'd0,    32'h0000_0000, 1'b1, 48'h0},
        '{STEP_CFG, REG_LOWER_MODE, FUNC_LOAD,  10'd0,    10'd0,    32'd1,         1'b0, 48'h0},
        '{STEP_CFG, REG_DIMENSION,  FUNC_LOAD,  10'd0,    10'd0,    32'd4,         1'b0, 48'h0},
        '{STEP_REQ, REG_DIMENSION,  FUNC_LOAD,  10'd2,    10'd0,    32'h0100_0000, 1'b0, 48'h0},
        '{STEP_REQ, REG_DIMENSION,  FUNC_LOAD,  10'd3,    10'd0,    32'hFF00_0000, 1'b0, 48'h0},
        '{STEP_REQ, REG_DIMENSION,  FUNC_ENTRY, 10'd3,    10'd2,    32'h0080_0000, 1'b0, 48'h0},
        // column above row: mirrored like a lower entry
        '{STEP_REQ, REG_DIMENSION,  FUNC_ENTRY, 10'd1,    10'd3,    32'h0100_0000, 1'b0, 48'h0},
        '{STEP_REQ, REG_DIMENSION,  FUNC_READ,  10'd3,    10'd0,    32'h0,
          1'b1, 48'h0000_0180_0000},
        '{STEP_REQ, REG_DIMENSION,  FUNC_READ,  10'd2,    10'd0,    32'h0,
          1'b1, 48'hFFFF_FF80_0000},
        // out of range: dropped without effect
        '{STEP_REQ, REG_DIMENSION,  FUNC_ENTRY, 10'd4,    10'd2,    32'h7FFF_FFFF, 1'b0, 48'h0},
        '{STEP_REQ, REG_DIMENSION,  FUNC_LOAD,  10'd4,    10'd0,    32'h1234_5678, 1'b0, 48'h0},
        '{STEP_REQ, REG_DIMENSION,  FUNC_READ,  10'd4,    10'd0,    32'h0000_0000, 1'b0, 48'h0},
        '{STEP_REQ, REG_DIMENSION,  FUNC_READ,  10'd1,    10'd0,    32'h0,
          1'b1, 48'hFFFF_FF00_0000},
        '{STEP_CFG, REG_DIMENSION,  FUNC_LOAD,  10'd0,    10'd0,    32'd0,         1'b0, 48'h0},
        '{STEP_REQ, REG_DIMENSION,  FUNC_ENTRY, 10'd3,    10'd3,    32'h0100_0000, 1'b0, 48'h0},
        '{STEP_REQ, REG_DIMENSION,  FUNC_READ,  10'd0,    10'd0,    32'h0000_0000, 1'b0, 48'h0},
        '{STEP_CFG, REG_DIMENSION,  FUNC_LOAD,  10'd0,    10'd0,    32'd2047,      1'b0, 48'h0},
        '{STEP_REQ, REG_DIMENSION,  FUNC_READ,  10'd1023, 10'd0,    32'h0000_0000, 1'b0, 48'h0},
        '{STEP_CFG, REG_DIMENSION,  FUNC_LOAD,  10'd0,    10'd0,    32'd1,         1'b0, 48'h0},
        '{STEP_REQ, REG_DIMENSION,  FUNC_ENTRY, 10'd0,    10'd0,    32'hFFFF_FFFF, 1'b0, 48'h0},
        '{STEP_REQ, REG_DIMENSION,  FUNC_READ,  10'd0,    10'd0,    32'h0000_0000, 1'b0, 48'h0},
        '{STEP_CFG, REG_LOWER_MODE, FUNC_LOAD,  10'd0,    10'd0,    32'd0,         1'b0, 48'h0},
        '{STEP_CFG, REG_DIMENSION,  FUNC_LOAD,  10'd0,    10'd0,    32'd1024,      1'b0, 48'h0}
    };

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic bit index_live(logic [IDX_W-1:0] idx);
        return idx < dim_model && int'(idx) < MAX_DIM;
    endfunction

    // Q8.24 times Q8.24, floored to Q24.24, added with 48-bit saturation
    function automatic logic signed [ACC_W-1:0] accumulate_q24(logic signed [ACC_W-1:0] acc,
                                                               logic signed [DATA_W-1:0] a,
                                                               logic signed [DATA_W-1:0] b);
        longint prod;
        longint sum;
        prod = longint'(a) * longint'(b);
        sum  = longint'(acc) + (prod >>> FRAC_W);
        if (sum > Y_HI) begin
            sum = Y_HI;
        end else if (sum < Y_LO) begin
            sum = Y_LO;
        end
        return sum[ACC_W-1:0];
    endfunction

    // Advance the predicted state by one request; return 1 when it yields a y element
    function automatic bit apply_to_model(t_func f, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                          logic signed [DATA_W-1:0] data, output t_y_read res);
        res.index = row;
        res.value = '0;
        case (f)
            FUNC_LOAD: begin
                if (index_live(row)) begin
                    x_model[row]  = data;
                    x_loaded[row] = 1'b1;
                end
            end
            FUNC_ENTRY: begin
                if (index_live(row) && index_live(col)) begin
                    y_model[row] = accumulate_q24(y_model[row], data, x_model[col]);
                    if (lower_model && col != row) begin
                        y_model[col] = accumulate_q24(y_model[col], data, x_model[row]);
                    end
                end
            end
            FUNC_READ: begin
                if (index_live(row)) begin
                    res.value    = y_model[row];
                    y_model[row] = '0;
                    return 1'b1;
                end
            end
            default: begin
            end
        endcase
        return 1'b0;
    endfunction

    function automatic logic [DATA_W-1:0] random_q8_24();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3, 4: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            default: return $urandom;
        endcase
    endfunction

    // Hold off between bursts of requests
    task automatic pace_sender();
        int gap;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_request(t_func f, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                logic [DATA_W-1:0] data, bit typed = 1'b0,
                                logic [ACC_W-1:0] typed_val = '0);
        t_y_read res;
        req_ch.valid      <= 1'b1;
        req_ch.func       <= f;
        req_ch.row_index  <= row;
        req_ch.col_index  <= col;
        req_ch.data_value <= data;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        if (apply_to_model(f, row, col, data, res)) begin
            if (typed) begin
                res.value = typed_val;
            end
            y_reads_due = {y_reads_due, res};
        end
        case (f)
            FUNC_LOAD:  n_loads++;
            FUNC_ENTRY: n_entries++;
            FUNC_READ:  n_reads++;
            default:    n_spare++;
        endcase
        pace_sender();
    endtask

    // Drop valid, wait for every pending y element, then let the back end settle
    task automatic quiesce(int settle);
        req_ch.valid <= 1'b0;
        while (y_reads_due.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg sel, logic [DIM_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= sel;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (sel == REG_DIMENSION) begin
            dim_model = value;
        end else begin
            lower_model = value[0];
        end
        n_settings++;
        @(posedge i_clk);
    endtask

    task automatic random_request(output bit live);
        int          span;
        int          roll;
        t_func       f;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        span = (int'(dim_model) < MAX_DIM) ? int'(dim_model) : MAX_DIM;
        roll = $urandom_range(0, 99);
        row  = IDX_W'($urandom_range(0, span - 1));
        col  = IDX_W'($urandom_range(0, span - 1));
        live = 1'b1;
        if (roll < 28) begin
            f = FUNC_LOAD;
        end else if (roll < 72) begin
            f = FUNC_ENTRY;
        end else if (roll < 94) begin
            f = FUNC_READ;
        end else begin
            live = 1'b0;
            if (span < MAX_DIM && roll < 98) begin
                f = t_func'($urandom_range(0, 2));
                if (f != FUNC_ENTRY || $urandom_range(0, 1) == 1) begin
                    row = IDX_W'($urandom_range(span, MAX_DIM - 1));
                end else begin
                    col = IDX_W'($urandom_range(span, MAX_DIM - 1));
                end
            end else begin
                f   = FUNC_SPARE;
                row = IDX_W'($urandom);
                col = IDX_W'($urandom);
            end
        end
        if (f != FUNC_ENTRY && live) begin
            col = IDX_W'($urandom);
        end
        // Load any x element the entry would read before it is ever written
        if (f == FUNC_ENTRY && live) begin
            if (!x_loaded[col]) begin
                send_request(FUNC_LOAD, col, IDX_W'($urandom), random_q8_24());
            end
            if (!x_loaded[row]) begin
                send_request(FUNC_LOAD, row, IDX_W'($urandom), random_q8_24());
            end
        end
        send_request(f, row, col, random_q8_24());
    endtask

    function automatic logic [DIM_W-1:0] phase_dimension(int ph);
        case (ph)
            0, 7:    return 11'd1024;
            1, 6:    return DIM_W'($urandom_range(2, 8));
            2:       return 11'd1;
            3:       return DIM_W'($urandom_range(9, 64));
            4:       return DIM_W'($urandom_range(1025, 2047));
            default: return DIM_W'($urandom_range(65, 1023));
        endcase
    endfunction

    initial begin
        t_plan_row step;
        bit        live;
        int        useful;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= REG_DIMENSION;
        i_cfg_data        <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.func       <= FUNC_LOAD;
        req_ch.row_index  <= '0;
        req_ch.col_index  <= '0;
        req_ch.data_value <= '0;
        foreach (y_model[k]) begin
            y_model[k]  = '0;
            x_model[k]  = '0;
            x_loaded[k] = 1'b0;
        end
        dim_model   = 11'd1024;
        lower_model = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_plan[k]) begin
            step = directed_plan[k];
            if (step.kind == STEP_CFG) begin
                quiesce(CFG_SETTLE);
                write_reg(step.sel, step.data[DIM_W-1:0]);
            end else begin
                send_request(step.func, step.row, step.col, step.data, step.typed, step.val);
            end
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            quiesce(CFG_SETTLE);
            write_reg(REG_DIMENSION, phase_dimension(ph));
            write_reg(REG_LOWER_MODE, {10'($urandom), ph[0]});
            useful = 0;
            while (useful < PHASE_REQS) begin
                random_request(live);
                useful += int'(live);
            end
        end

        quiesce(DRAIN_CYCLES);
        $display("Sent %0d loads, %0d matrix entries, %0d reads and %0d unused-code requests",
                 n_loads, n_entries, n_reads, n_spare);
        $display("over %0d register writes; %0d y elements returned, %0d mismatches",
                 n_settings, n_results, mismatches);
        if (mismatches == 0 && y_reads_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Receiver: ready stretches of random length broken by short and long stalls
    initial begin
        rsp_ch.ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            rsp_ch.ready <= 1'b1;
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                : $urandom_range(1, 24)) @(posedge i_clk);
            rsp_ch.ready <= 1'b0;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 5)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_y_read due;
        if (rsp_ch.valid && rsp_ch.ready) begin
            n_results++;
            if (y_reads_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected y element: index %0d value %h",
                             rsp_ch.result_index, rsp_ch.result_value);
                end
            end else begin
                due = y_reads_due.pop_front();
                if (rsp_ch.result_index !== due.index || rsp_ch.result_value !== due.value) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("y mismatch: expected index %0d value %h, got index %0d value %h",
                                 due.index, due.value,
                                 rsp_ch.result_index, rsp_ch.result_value);
                    end
                end
            end
        end
    end

    // Watchdog: end the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles == STALL_LIMIT) begin
            $display("watchdog: no request or result moved for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

endmodule

// ----- files.f -----
hdl/smv_pkg.sv
hdl/smv_req_if.sv
hdl/smv_rsp_if.sv
hdl/smv_ram.sv
hdl/smv_front.sv
hdl/smv_queue.sv
hdl/smv_back.sv
hdl/sparse_matvec_csr_symmetric.sv
tb/sv/sparse_matvec_csr_symmetric_tb.sv
